>>> rtl/betc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package betc_pkg;

  // Table size default, handed to the top level parameter
  localparam int ENTRIES_DEFAULT = 8;

  localparam int BLK_W    = 64;
  localparam int LEN_W    = 16;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;

  // Operation codes on the mode field
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FILL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRUNC  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_MISS      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_HIT       = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FILLED    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 3'd4;

  // One extent as it sits in the table memory
  typedef struct packed {
    logic [BLK_W-1:0] lstart;
    logic [BLK_W-1:0] pstart;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_TRANS,
    S_FINISH
  } state_t;

  // diff_ext is {borrow, blk - start}; the block lies in the extent when
  // there is no borrow and the offset is below the length
  function automatic logic in_extent(input logic [BLK_W:0] diff_ext,
                                     input logic [LEN_W-1:0] len);
    logic hi_zero;
    hi_zero = (diff_ext[BLK_W-1:LEN_W] == '0);
    return !diff_ext[BLK_W] && hi_zero && (diff_ext[LEN_W-1:0] < len);
  endfunction

endpackage

`default_nettype wire

>>> rtl/block_extent_translation_cache.sv
`timescale 1ns / 1ps
`default_nettype none

// Extent translation cache: ENTRIES extents (logical start, physical start,
// length) in a single-port-read table memory. One word is worked on at a
// time. A lookup reads the MRU entry first and then walks the table one
// entry per cycle through the memory read port. A truncate always walks
// the whole table. A result is held back while the last one is still
// stalled, and the next word can be taken in the same cycle as the result
// is raised. Per-entry valid bits clear the table at reset at once; no
// clearing pass is needed.
module block_extent_translation_cache import betc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [BLK_W-1:0]    block_index,
  input  wire logic                create,
  input  wire logic [BLK_W-1:0]    extent_start,
  input  wire logic [BLK_W-1:0]    extent_phys,
  input  wire logic [LEN_W-1:0]    extent_count,
  input  wire logic [BLK_W-1:0]    eof_block,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [STATUS_W-1:0] status,
  output logic      [BLK_W-1:0]    phys_block
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ENT_W = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] LAST_K   = CNT_W'(ENTRIES);

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  state_t state, state_next;

  // held word
  logic [MODE_W-1:0] op_mode;
  logic [BLK_W-1:0]  op_blk;
  logic              op_create;
  logic [BLK_W-1:0]  op_xstart;
  logic [BLK_W-1:0]  op_xphys;
  logic [LEN_W-1:0]  op_xcount;
  logic [BLK_W-1:0]  op_lastb;

  // pointers and per-entry valid bits
  logic [IDX_W-1:0]   mru;
  logic [IDX_W-1:0]   victim;
  logic [ENTRIES-1:0] valid;

  // scan sequencer: k = 0 reads the MRU entry, k = i+1 reads entry i
  logic [CNT_W-1:0] issue_k;
  logic [CNT_W-1:0] eval_k;
  logic [IDX_W-1:0] eval_addr;
  logic             eval_valid;

  // translation stage and result
  logic [BLK_W-1:0]    t_pstart;
  logic [BLK_W-1:0]    t_diff;
  logic [STATUS_W-1:0] res_status;
  logic [BLK_W-1:0]    res_phys;

  // memory port
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;

  logic             in_accept;
  logic [IDX_W-1:0] issue_addr;
  entry_t           entry_rd;
  logic             op_is_lookup;
  logic             skip;
  logic [BLK_W-1:0] cmp_start;
  logic [LEN_W-1:0] cmp_len;
  logic [BLK_W:0]   diff_ext;
  logic             covered;
  logic             scan_hit;
  logic             scan_last;
  logic             trunc_clear;
  logic             fill_bad;
  logic [BLK_W-1:0] trans_phys;
  logic             out_free;

  betc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Datapath around the table read
  always_comb begin
    in_accept    = in_valid && !in_stall;
    issue_addr   = (issue_k == '0) ? mru : IDX_W'(issue_k - 1'b1);
    entry_rd     = valid[eval_addr] ? entry_t'(rd_data) : '0;
    op_is_lookup = (op_mode == MODE_LOOKUP);
    skip         = (eval_k != '0) && (eval_addr == mru);
    cmp_start    = (state == S_FILL) ? op_xstart : entry_rd.lstart;
    cmp_len      = (state == S_FILL) ? op_xcount : entry_rd.len;
    diff_ext     = {1'b0, op_blk} - {1'b0, cmp_start};
    covered      = in_extent(diff_ext, cmp_len);
    scan_hit     = (state == S_SCAN) && eval_valid && op_is_lookup && !skip && covered;
    scan_last    = eval_valid && (eval_k == LAST_K);
    trunc_clear  = (state == S_SCAN) && eval_valid && !op_is_lookup
                   && (op_lastb <= entry_rd.lstart);
    fill_bad     = op_create ? ((op_xphys == '0) || !covered)
                             : ((op_xphys != '0) && !covered);
    trans_phys   = (t_pstart == '0) ? '0 : t_pstart + t_diff;
    out_free     = !out_valid || !out_stall;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_LOOKUP: state_next = S_SCAN;
            MODE_TRUNC:  state_next = S_SCAN;
            MODE_FILL:   state_next = S_FILL;
            default:     state_next = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_TRANS;
        end else if (scan_last) begin
          state_next = S_FINISH;
        end
      end
      S_FILL: begin
        state_next = fill_bad ? S_FINISH : S_TRANS;
      end
      S_TRANS: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs; the table is written only in the fill state, never
  // while a scan is reading it
  always_comb begin
    in_stall = (state != S_IDLE);
    rd_addr  = issue_addr;
    wr_en    = (state == S_FILL) && !fill_bad;
    wr_addr  = victim;
    wr_data  = {op_xstart, op_xphys, op_xcount};
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mru        <= '0;
      victim     <= '0;
      valid      <= '0;
      eval_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (in_accept) begin
        eval_valid <= 1'b0;
      end else if (state == S_SCAN) begin
        eval_valid <= 1'b1;
      end

      // lookup hit found by the walk moves the pointers
      if (scan_hit) begin
        mru <= eval_addr;
        if (eval_k != '0 && eval_addr == victim) begin
          victim <= advance(victim);
        end
      end

      if (trunc_clear) begin
        valid[eval_addr] <= 1'b0;
      end

      if (state == S_FILL && !fill_bad) begin
        valid[victim] <= 1'b1;
        mru           <= victim;
        victim        <= advance(victim);
      end

      // write to a hole: the next fill replaces the entry just hit
      if (state == S_TRANS && op_is_lookup && op_create && trans_phys == '0) begin
        victim <= mru;
      end

      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and sequencer registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_mode    <= mode;
      op_blk     <= block_index;
      op_create  <= create;
      op_xstart  <= extent_start;
      op_xphys   <= extent_phys;
      op_xcount  <= extent_count;
      op_lastb   <= eof_block;
      issue_k    <= '0;
      eval_k     <= '0;
      eval_addr  <= '0;
      res_status <= (mode == MODE_TRUNC) ? STATUS_TRUNCATED : STATUS_MISS;
      res_phys   <= '0;
    end

    // walk: issue one read per cycle, evaluate the previous one
    if (state == S_SCAN) begin
      eval_k    <= issue_k;
      eval_addr <= issue_addr;
      if (issue_k != LAST_K) begin
        issue_k <= issue_k + 1'b1;
      end
    end

    if (scan_hit) begin
      t_pstart   <= entry_rd.pstart;
      t_diff     <= diff_ext[BLK_W-1:0];
      res_status <= STATUS_HIT;
    end

    if (state == S_FILL) begin
      t_pstart   <= op_xphys;
      t_diff     <= diff_ext[BLK_W-1:0];
      res_status <= fill_bad ? STATUS_REJECTED : STATUS_FILLED;
    end

    if (state == S_TRANS) begin
      res_phys <= trans_phys;
    end

    if (state == S_FINISH && out_free) begin
      status     <= res_status;
      phys_block <= res_phys;
    end
  end

endmodule

`default_nettype wire

>>> rtl/betc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module betc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/betc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module betc_checker import betc_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [BLK_W-1:0]    phys_block
);

  // a held result word does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(phys_block))
    else $error("stalled result word changed");

  // one word at a time: an accepted word makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= STATUS_TRUNCATED)
    else $error("undefined status code");

  // miss, rejected fill and truncate carry no translation
  a_no_phys: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_MISS || status == STATUS_REJECTED ||
                  status == STATUS_TRUNCATED) |-> phys_block == '0)
    else $error("translation on a result that has none");

endmodule

bind block_extent_translation_cache betc_checker u_betc_checker (.*);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

import betc_pkg::*;

module tb;

  // Mode 3 has no meaning; the block must answer it with a plain miss
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1250;

  typedef struct packed {
    logic [MODE_W-1:0] op;
    logic [BLK_W-1:0]  blk;
    logic              create;
    logic [BLK_W-1:0]  xstart;
    logic [BLK_W-1:0]  xphys;
    logic [LEN_W-1:0]  xcount;
    logic [BLK_W-1:0]  lastb;
  } blk_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [BLK_W-1:0]    phys;
  } xlat_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

  // Shadow of the extent table plus the queue of translations still owed
  class xlat_checker;
    bit [BLK_W-1:0] lstart [ENTRIES_DEFAULT];
    bit [BLK_W-1:0] pstart [ENTRIES_DEFAULT];
    bit [LEN_W-1:0] len [ENTRIES_DEFAULT];
    int unsigned mru;
    int unsigned victim;
    xlat_t pending_xlat[$];
    int errors;
    int n_words, n_hit, n_miss, n_fill, n_rej, n_trunc;

    function bit covers(bit [BLK_W-1:0] b, bit [BLK_W-1:0] s, bit [LEN_W-1:0] l);
      return (b >= s) && ((b - s) < {48'd0, l});
    endfunction

    function bit [BLK_W-1:0] map_blk(bit [BLK_W-1:0] b, bit [BLK_W-1:0] ls,
                                     bit [BLK_W-1:0] ps);
      return (ps == '0) ? '0 : ps + (b - ls);
    endfunction

    // Work out the translation for one accepted word and update the table
    function void note_word(blk_req_t w);
      bit hit;
      bit bad;
      int unsigned m;
      xlat_t res;
      res.st = STATUS_MISS;
      res.phys = '0;
      hit = 1'b0;
      m = mru;
      n_words++;
      case (w.op)
        MODE_LOOKUP: begin
          if (covers(w.blk, lstart[m], len[m])) begin
            hit = 1'b1;
            res.phys = map_blk(w.blk, lstart[m], pstart[m]);
          end else begin
            for (int i = 0; i < ENTRIES_DEFAULT; i++) begin
              if (!hit && i != m && len[i] != 0 && covers(w.blk, lstart[i], len[i])) begin
                hit = 1'b1;
                res.phys = map_blk(w.blk, lstart[i], pstart[i]);
                mru = i;
                if (i == victim) victim = (victim + 1) % ENTRIES_DEFAULT;
              end
            end
          end
          if (hit) begin
            res.st = STATUS_HIT;
            // write into a hole: next fill goes over this entry
            if (res.phys == '0 && w.create) victim = mru;
            n_hit++;
          end else begin
            n_miss++;
          end
        end
        MODE_FILL: begin
          if (w.create)
            bad = (w.xphys == '0) || !covers(w.blk, w.xstart, w.xcount);
          else
            bad = (w.xphys != '0) && !covers(w.blk, w.xstart, w.xcount);
          if (bad) begin
            res.st = STATUS_REJECTED;
            n_rej++;
          end else begin
            lstart[victim] = w.xstart;
            pstart[victim] = w.xphys;
            len[victim] = w.xcount;
            res.phys = map_blk(w.blk, w.xstart, w.xphys);
            res.st = STATUS_FILLED;
            mru = victim;
            victim = (victim + 1) % ENTRIES_DEFAULT;
            n_fill++;
          end
        end
        MODE_TRUNC: begin
          for (int i = 0; i < ENTRIES_DEFAULT; i++) begin
            if (w.lastb <= lstart[i]) begin
              lstart[i] = '0;
              pstart[i] = '0;
              len[i] = '0;
            end
          end
          res.st = STATUS_TRUNCATED;
          n_trunc++;
        end
        default: ;
      endcase
      pending_xlat.push_back(res);
    endfunction

    task report(string what, logic [BLK_W-1:0] got, logic [BLK_W-1:0] want);
      errors++;
      if (errors <= 40)
        $display("mismatch at %0t: %s got %h, expected %h", $realtime, what, got, want);
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [BLK_W-1:0] phys);
      xlat_t want;
      if (pending_xlat.size() == 0) begin
        report("unexpected result word, status", {61'd0, st}, '0);
      end else begin
        want = pending_xlat.pop_front();
        if (st !== want.st) report("status", {61'd0, st}, {61'd0, want.st});
        if (phys !== want.phys) report("phys_block", phys, want.phys);
      end
    endtask

    function int pending();
      return pending_xlat.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [BLK_W-1:0] block_index = '0;
  logic create = 1'b0;
  logic [BLK_W-1:0] extent_start = '0;
  logic [BLK_W-1:0] extent_phys = '0;
  logic [LEN_W-1:0] extent_count = '0;
  logic [BLK_W-1:0] eof_block = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [BLK_W-1:0] phys_block;

  xlat_checker sb;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_cnt = 0;
  stall_style_t stall_style = STALL_NONE;
  logic [BLK_W-1:0] known_start [8];
  logic [LEN_W-1:0] known_count [8];
  int known_idx = 0;

  block_extent_translation_cache #(.ENTRIES(ENTRIES_DEFAULT)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .block_index(block_index), .create(create),
    .extent_start(extent_start), .extent_phys(extent_phys),
    .extent_count(extent_count), .eof_block(eof_block),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .phys_block(phys_block)
  );

  always #6 clk = ~clk;

  function automatic logic [BLK_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Unused fields carry junk so every input bit toggles
  function automatic blk_req_t junk_word();
    blk_req_t w;
    w.op = MODE_LOOKUP;
    w.blk = rand64();
    w.create = 1'($urandom_range(0, 1));
    w.xstart = rand64();
    w.xphys = rand64();
    w.xcount = LEN_W'($urandom_range(0, 65535));
    w.lastb = rand64();
    return w;
  endfunction

  // Mostly a small window so extents overlap; some far out and near the top
  function automatic logic [BLK_W-1:0] pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return BLK_W'($urandom_range(0, 4095));
    if (r == 8) return rand64();
    return 64'hFFFF_FFFF_FFFF_F000 + BLK_W'($urandom_range(0, 4095));
  endfunction

  // Present one word and hold it until accepted; bursts and gaps on the sender side
  task automatic send_word(blk_req_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= w.op;
    block_index <= w.blk;
    create <= w.create;
    extent_start <= w.xstart;
    extent_phys <= w.xphys;
    extent_count <= w.xcount;
    eof_block <= w.lastb;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic do_lookup(logic [BLK_W-1:0] blk, logic cr);
    blk_req_t w;
    w = junk_word();
    w.op = MODE_LOOKUP;
    w.blk = blk;
    w.create = cr;
    send_word(w);
  endtask

  task automatic do_fill(logic [BLK_W-1:0] blk, logic cr, logic [BLK_W-1:0] xs,
                         logic [BLK_W-1:0] xp, logic [LEN_W-1:0] xc);
    blk_req_t w;
    w = junk_word();
    w.op = MODE_FILL;
    w.blk = blk;
    w.create = cr;
    w.xstart = xs;
    w.xphys = xp;
    w.xcount = xc;
    known_start[known_idx] = xs;
    known_count[known_idx] = xc;
    known_idx = (known_idx + 1) % 8;
    send_word(w);
  endtask

  task automatic do_trunc(logic [BLK_W-1:0] lb);
    blk_req_t w;
    w = junk_word();
    w.op = MODE_TRUNC;
    w.lastb = lb;
    send_word(w);
  endtask

  task automatic do_unused();
    blk_req_t w;
    w = junk_word();
    w.op = MODE_UNUSED;
    send_word(w);
  endtask

  // Receiver stall, switching between four random and periodic styles
  always @(posedge clk) begin
    stall_cnt++;
    if (stall_cnt % 300 == 0) stall_style = stall_style_t'($urandom_range(0, 3));
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_style)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
        STALL_PERIODIC: out_stall <= ((stall_cnt % 7) < 3);
        default:        out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Handshake monitor and watchdog
  always @(posedge clk) begin
    blk_req_t w;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        w.op = mode;
        w.blk = block_index;
        w.create = create;
        w.xstart = extent_start;
        w.xphys = extent_phys;
        w.xcount = extent_count;
        w.lastb = eof_block;
        sb.note_word(w);
      end
      if (out_valid && !out_stall) sb.check_result(status, phys_block);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.pending());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [BLK_W-1:0] xs, xp, blk;
    logic [LEN_W-1:0] xc;
    int sel, r, k;
    sb = new;
    for (int i = 0; i < 8; i++) begin
      known_start[i] = '0;
      known_count[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, fill checks, holes, wrap limits, truncates
    do_lookup('0, 1'b0);
    do_lookup('1, 1'b1);
    do_trunc('1);
    do_fill(64'd7, 1'b0, '0, '0, '0);                 // empty hole extent accepted
    do_fill(64'd103, 1'b1, 64'd100, '0, 16'd10);      // write into hole: rejected
    do_fill(64'd110, 1'b1, 64'd100, 64'd5000, 16'd10); // just past end: rejected
    do_fill(64'd99, 1'b0, 64'd100, 64'd5000, 16'd10);  // read outside: rejected
    do_fill(64'd109, 1'b1, 64'd100, 64'd5000, 16'd10);
    do_fill(64'd205, 1'b0, 64'd200, '0, 16'd20);
    do_lookup(64'd205, 1'b1);                         // write hit on a hole
    do_fill(64'd210, 1'b1, 64'd200, 64'd7000, 16'd20);
    do_lookup(64'd103, 1'b0);
    do_fill('1, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, '1, 16'hFFFF);
    do_lookup('0, 1'b0);                              // extent must not wrap to 0
    do_fill(64'd65534, 1'b0, '0, 64'd1, 16'hFFFF);
    do_lookup(64'd65535, 1'b0);
    do_lookup(64'd65534, 1'b1);
    do_fill('1, 1'b0, '1, 64'd12345, 16'hFFFF);
    do_unused();
    do_trunc(64'd150);
    do_lookup(64'd205, 1'b0);
    do_lookup(64'd1000, 1'b0);
    do_trunc('0);
    do_lookup(64'd103, 1'b0);

    // Random: mostly well-formed fills and lookups aimed at recent extents
    for (k = 0; k < N_RANDOM; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          r = $urandom_range(0, 7);
          blk = known_start[r];
          if (known_count[r] != 0)
            blk = blk + BLK_W'($urandom_range(0, known_count[r]));
        end else if (r < 9) begin
          blk = pick_base();
        end else begin
          blk = rand64();
        end
        do_lookup(blk, 1'($urandom_range(0, 1)));
      end else if (sel < 88) begin
        xs = pick_base();
        r = $urandom_range(0, 19);
        if (r == 0) xc = '0;
        else if (r == 1) xc = '1;
        else if (r == 2) xc = LEN_W'($urandom_range(0, 65535));
        else xc = LEN_W'($urandom_range(1, 64));
        r = $urandom_range(0, 19);
        if (r < 3) xp = '0;
        else if (r < 5) xp = BLK_W'($urandom_range(1, 255));
        else xp = rand64();
        if ($urandom_range(0, 99) < 85) begin
          blk = xs;
          if (xc != 0) blk = xs + BLK_W'($urandom_range(0, xc - 1));
        end else begin
          r = $urandom_range(0, 2);
          if (r == 0) blk = xs + BLK_W'(xc);
          else if (r == 1) blk = xs - 1;
          else blk = rand64();
        end
        do_fill(blk, 1'($urandom_range(0, 1)), xs, xp, xc);
      end else if (sel < 96) begin
        r = $urandom_range(0, 9);
        if (r < 4) blk = pick_base();
        else if (r < 7) blk = known_start[$urandom_range(0, 7)] + BLK_W'($urandom_range(0, 1));
        else if (r == 7) blk = '0;
        else if (r == 8) blk = '1;
        else blk = rand64();
        do_trunc(blk);
      end else begin
        do_unused();
      end
    end
    in_valid <= 1'b0;

    // Drain, then give a late or extra result time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * ENTRIES_DEFAULT + 8) @(posedge clk);

    $display("covered %0d words: %0d hits, %0d misses, %0d fills, %0d rejected fills,",
             sb.n_words, sb.n_hit, sb.n_miss, sb.n_fill, sb.n_rej);
    $display("  %0d truncates; %0d mismatches", sb.n_trunc, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/betc_pkg.sv
rtl/betc_ram.sv
rtl/block_extent_translation_cache.sv
rtl/betc_checker.sv
verif/tb.sv
